@@ rtl/mqm_pkg.sv @@
// Package for the multi-queue manager: sizes, codes, transaction types and helpers.
package mqm_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int POOL_DEPTH = 64;
    localparam int DATA_WIDTH = 32;

    localparam int PTR_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
    localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int MASK_W = 4;
    localparam int MASK_Q = (NUM_QUEUES < MASK_W) ? NUM_QUEUES : MASK_W;

    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef enum logic [1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_PEEK = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         queue_index;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic [MASK_W-1:0]  empty_mask;
    } rsp_t;

    // Successor of a slot in the initial free chain, wrapping at the pool end.
    function automatic ptr_t next_slot(input ptr_t s);
        ptr_t r;
        if (s == ptr_t'(POOL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + ptr_t'(1);
        end
        return r;
    endfunction

    function automatic logic [31:0] to_result(input data_t d);
        logic [63:0] w;
        w = 64'(d);
        return w[31:0];
    endfunction

    function automatic data_t to_data(input logic [31:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/mqm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module mqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/multi_queue_manager_top.sv @@
// Top level of the multi-queue manager: linked-list FIFO queues in a shared entry pool.
// done is high in the cycle after the execution cycle.
// A new transaction is taken only while idle; busy is high for the single cycle in which
// the data and link memories return the entry read at acceptance.
// The receiver cannot stall; done marks each result for one cycle only.
// Reset empties all queues at once: a fill mark stands for the initial free chain, no clear pass.
module multi_queue_manager_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mqm_pkg::req_t       req,
    output logic                done,
    output mqm_pkg::rsp_t       rsp
);

    mqm_pkg::state_t state_reg, state_next;
    logic            exec;
    logic            accept;

    logic [1:0]      kind_reg;
    logic [1:0]      q_reg;
    logic [31:0]     value_reg;

    mqm_pkg::ptr_t   head_reg [mqm_pkg::NUM_QUEUES];
    mqm_pkg::ptr_t   head_next [mqm_pkg::NUM_QUEUES];
    mqm_pkg::ptr_t   tail_reg [mqm_pkg::NUM_QUEUES];
    mqm_pkg::ptr_t   tail_next [mqm_pkg::NUM_QUEUES];
    logic [mqm_pkg::NUM_QUEUES-1:0] nonempty_reg, nonempty_next;
    mqm_pkg::ptr_t   free_head_reg, free_head_next;
    mqm_pkg::cnt_t   free_count_reg, free_count_next;
    mqm_pkg::cnt_t   fresh_reg, fresh_next;

    logic            done_reg;
    mqm_pkg::rsp_t   rsp_reg, rsp_next;

    logic [mqm_pkg::QSEL_W-1:0] q_acc;
    logic [mqm_pkg::QSEL_W-1:0] q_sel;
    logic            q_ok;

    logic            data_we;
    mqm_pkg::ptr_t   data_waddr;
    mqm_pkg::data_t  data_wdata;
    mqm_pkg::ptr_t   data_raddr;
    mqm_pkg::data_t  data_rdata;

    logic            link_we;
    mqm_pkg::ptr_t   link_waddr;
    mqm_pkg::ptr_t   link_wdata;
    mqm_pkg::ptr_t   link_raddr;
    mqm_pkg::ptr_t   link_rdata;
    mqm_pkg::ptr_t   link_eff;

    mqm_pkg::ptr_t   slot;
    logic [mqm_pkg::MASK_W-1:0] mask;

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mqm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mqm_pkg::ST_EXEC;
                end
            end
            mqm_pkg::ST_EXEC:
            begin
                state_next = mqm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mqm_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        busy = 1'b0;
        exec = 1'b0;
        unique case (state_reg)
            mqm_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
            mqm_pkg::ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;
    assign q_acc  = mqm_pkg::QSEL_W'(req.queue_index);
    assign q_sel  = mqm_pkg::QSEL_W'(q_reg);
    assign q_ok   = int'(q_reg) < mqm_pkg::NUM_QUEUES;

    assign data_raddr = head_reg[q_acc];
    assign link_raddr = (req.kind == mqm_pkg::KIND_ENQ) ? free_head_reg : head_reg[q_acc];

    // Entries at or above the fill mark were never allocated and still chain to their successor.
    assign link_eff = (mqm_pkg::CNT_W'(free_head_reg) >= fresh_reg) ?
                      mqm_pkg::next_slot(free_head_reg) : link_rdata;

    // Read-modify-write of the pool and the queue descriptors
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        nonempty_next   = nonempty_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        data_we         = 1'b0;
        data_waddr      = free_head_reg;
        data_wdata      = mqm_pkg::to_data(value_reg);
        link_we         = 1'b0;
        link_waddr      = tail_reg[q_sel];
        link_wdata      = free_head_reg;
        slot            = head_reg[q_sel];
        mask            = '1;
        rsp_next        = rsp_reg;

        if (exec)
        begin
            rsp_next.result_value = '0;
            rsp_next.status       = mqm_pkg::STATUS_OK;
            if (kind_reg == mqm_pkg::KIND_NONE)
            begin
                rsp_next.status = mqm_pkg::STATUS_OK;
            end
            else if (!q_ok)
            begin
                rsp_next.status = mqm_pkg::STATUS_EMPTY;
            end
            else if (kind_reg == mqm_pkg::KIND_ENQ)
            begin
                if (free_count_reg == '0)
                begin
                    rsp_next.status = mqm_pkg::STATUS_FULL;
                end
                else
                begin
                    free_head_next  = link_eff;
                    free_count_next = free_count_reg - mqm_pkg::cnt_t'(1);
                    if (mqm_pkg::CNT_W'(free_head_reg) >= fresh_reg)
                    begin
                        fresh_next = fresh_reg + mqm_pkg::cnt_t'(1);
                    end
                    data_we = 1'b1;
                    if (nonempty_reg[q_sel])
                    begin
                        link_we    = 1'b1;
                        link_waddr = tail_reg[q_sel];
                        link_wdata = free_head_reg;
                    end
                    else
                    begin
                        head_next[q_sel] = free_head_reg;
                    end
                    tail_next[q_sel]     = free_head_reg;
                    nonempty_next[q_sel] = 1'b1;
                end
            end
            else if (!nonempty_reg[q_sel])
            begin
                rsp_next.status = mqm_pkg::STATUS_EMPTY;
            end
            else
            begin
                rsp_next.result_value = mqm_pkg::to_result(data_rdata);
                if (kind_reg == mqm_pkg::KIND_DEQ)
                begin
                    if (slot == tail_reg[q_sel])
                    begin
                        nonempty_next[q_sel] = 1'b0;
                    end
                    else
                    begin
                        head_next[q_sel] = link_rdata;
                    end
                    link_we        = 1'b1;
                    link_waddr     = slot;
                    link_wdata     = free_head_reg;
                    free_head_next = slot;
                    if (int'(free_count_reg) < mqm_pkg::POOL_DEPTH)
                    begin
                        free_count_next = free_count_reg + mqm_pkg::cnt_t'(1);
                    end
                end
            end

            for (int i = 0; i < mqm_pkg::MASK_Q; i++)
            begin
                mask[i] = !nonempty_next[i];
            end
            rsp_next.empty_mask = mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mqm_pkg::ST_IDLE;
            nonempty_reg   <= '0;
            free_head_reg  <= '0;
            free_count_reg <= mqm_pkg::cnt_t'(mqm_pkg::POOL_DEPTH);
            fresh_reg      <= '0;
            done_reg       <= 1'b0;
            for (int i = 0; i < mqm_pkg::NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            nonempty_reg   <= nonempty_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            done_reg       <= exec;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= req.kind;
            q_reg     <= req.queue_index;
            value_reg <= req.value;
        end
        rsp_reg <= rsp_next;
    end

    mqm_ram #(
        .WIDTH (mqm_pkg::DATA_WIDTH),
        .DEPTH (mqm_pkg::POOL_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (accept),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    mqm_ram #(
        .WIDTH (mqm_pkg::PTR_W),
        .DEPTH (mqm_pkg::POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not enter execution");

    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execution did not deliver exactly one result");

    a_done_only_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in execution");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(free_count_reg) <= mqm_pkg::POOL_DEPTH)
        else $error("free count exceeds pool depth");

    a_full_only_when_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == mqm_pkg::STATUS_FULL) |-> free_count_reg == '0)
        else $error("pool full reported with free entries left");

endmodule

@@ sim/mqm_checker.sv @@
// Scoreboard for the multi-queue manager: tracks the queues, predicts each result and compares.
module mqm_checker
    import mqm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  busy,
    input  req_t  req,
    input  logic  done,
    input  rsp_t  rsp,
    output int    fail_count,
    output int    outstanding,
    output int    checked,
    output int    full_hits,
    output int    empty_hits
);

    data_t slot_data [POOL_DEPTH];
    ptr_t  slot_link [POOL_DEPTH];
    ptr_t  q_head    [NUM_QUEUES];
    ptr_t  q_tail    [NUM_QUEUES];
    logic  q_live    [NUM_QUEUES];
    ptr_t  free_top;
    cnt_t  free_cnt;

    rsp_t  expected_rsp_q [$];

    function automatic rsp_t apply_queue_op(input req_t r);
        rsp_t        e;
        int          qi;
        ptr_t        s;
        logic [63:0] w;
        e = '0;
        e.status = STATUS_OK;
        qi = int'(r.queue_index);
        if (r.kind == KIND_NONE)
        begin
            e.status = STATUS_OK;
        end
        else if (qi >= NUM_QUEUES)
        begin
            e.status = STATUS_EMPTY;
        end
        else if (r.kind == KIND_ENQ)
        begin
            if (free_cnt == 0)
            begin
                e.status = STATUS_FULL;
            end
            else
            begin
                s = free_top;
                free_top = slot_link[s];
                free_cnt = free_cnt - cnt_t'(1);
                slot_data[s] = data_t'($unsigned(r.value));
                if (q_live[qi])
                begin
                    slot_link[q_tail[qi]] = s;
                end
                else
                begin
                    q_head[qi] = s;
                end
                q_tail[qi] = s;
                q_live[qi] = 1'b1;
            end
        end
        else if (!q_live[qi])
        begin
            e.status = STATUS_EMPTY;
        end
        else
        begin
            s = q_head[qi];
            w = '0;
            w[DATA_WIDTH-1:0] = slot_data[s];
            e.result_value = w[31:0];
            if (r.kind == KIND_DEQ)
            begin
                if (s == q_tail[qi])
                begin
                    q_live[qi] = 1'b0;
                end
                else
                begin
                    q_head[qi] = slot_link[s];
                end
                slot_link[s] = free_top;
                free_top = s;
                if (free_cnt < cnt_t'(POOL_DEPTH))
                begin
                    free_cnt = free_cnt + cnt_t'(1);
                end
            end
        end
        for (int b = 0; b < MASK_W; b++)
        begin
            if (b >= NUM_QUEUES || !q_live[b])
            begin
                e.empty_mask[b] = 1'b1;
            end
        end
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                slot_data[i] = '0;
                slot_link[i] = ptr_t'((i + 1) % POOL_DEPTH);
            end
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                q_head[i] = '0;
                q_tail[i] = '0;
                q_live[i] = 1'b0;
            end
            free_top = '0;
            free_cnt = cnt_t'(POOL_DEPTH);
            expected_rsp_q.delete();
            fail_count  = 0;
            checked     = 0;
            full_hits   = 0;
            empty_hits  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("result strobe with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    e = expected_rsp_q.pop_front();
                    checked++;
                    if (e.status == STATUS_FULL)
                    begin
                        full_hits++;
                    end
                    if (e.status == STATUS_EMPTY)
                    begin
                        empty_hits++;
                    end
                    if (rsp.result_value !== e.result_value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               e.result_value, rsp.result_value);
                        fail_count++;
                    end
                    if (rsp.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.empty_mask !== e.empty_mask)
                    begin
                        $error("empty_mask: expected %b, got %b",
                               e.empty_mask, rsp.empty_mask);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_rsp_q.push_back(apply_queue_op(req));
            end
            outstanding <= expected_rsp_q.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for the multi-queue manager: clock, reset, request stimulus and verdict.
module tb;
    import mqm_pkg::*;

    localparam int RANDOM_ITEMS = 1030;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 200000;

    localparam req_t DIRECTED [22] = '{
        '{KIND_PEEK, 2'd0, 32'sh0000_0000},
        '{KIND_DEQ,  2'd0, 32'sh0000_0000},
        '{KIND_NONE, 2'd1, 32'shffff_ffff},
        '{KIND_ENQ,  2'd0, 32'sh8000_0000},
        '{KIND_ENQ,  2'd0, 32'sh7fff_ffff},
        '{KIND_ENQ,  2'd1, 32'sh0000_0000},
        '{KIND_ENQ,  2'd2, 32'shffff_ffff},
        '{KIND_ENQ,  2'd3, 32'sh5555_5555},
        '{KIND_ENQ,  2'd3, 32'shaaaa_aaaa},
        '{KIND_PEEK, 2'd0, 32'sh1234_5678},
        '{KIND_DEQ,  2'd0, 32'sh0000_0000},
        '{KIND_PEEK, 2'd0, 32'sh0000_0000},
        '{KIND_DEQ,  2'd0, 32'sh0000_0000},
        '{KIND_DEQ,  2'd0, 32'sh0000_0000},
        '{KIND_PEEK, 2'd1, 32'sh0000_0000},
        '{KIND_DEQ,  2'd1, 32'sh0000_0000},
        '{KIND_DEQ,  2'd2, 32'sh0000_0000},
        '{KIND_PEEK, 2'd3, 32'sh0000_0000},
        '{KIND_DEQ,  2'd3, 32'sh0000_0000},
        '{KIND_DEQ,  2'd3, 32'sh0000_0000},
        '{KIND_PEEK, 2'd3, 32'sh0000_0000},
        '{KIND_PEEK, 2'd2, 32'sh0000_0000}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    int          fail_count;
    int          outstanding;
    int          checked;
    int          full_hits;
    int          empty_hits;
    int unsigned cycle_count = 0;

    multi_queue_manager_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    mqm_checker u_mqm_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked),
        .full_hits   (full_hits),
        .empty_hits  (empty_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // holds the transaction until the edge at which it is taken
    task automatic send_request(input req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin
        req_t r;
        int   sent;
        int   phase;
        int   phase_len;
        int   enq_pct;
        int   idle_pct;
        int   pick;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_request(DIRECTED[i]);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // fill towards the pool limit, drain, then mixed traffic, repeating in that order
            case (phase % 3)
                0: enq_pct = 85;
                1: enq_pct = 20;
                default: enq_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 50;
            endcase
            phase_len = (phase == 0) ? 120 : $urandom_range(40, 120);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    r.kind = KIND_NONE;
                end
                else if (pick < enq_pct)
                begin
                    r.kind = KIND_ENQ;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    r.kind = KIND_PEEK;
                end
                else
                begin
                    r.kind = KIND_DEQ;
                end
                r.queue_index = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0: r.value = 32'sh8000_0000;
                    1: r.value = 32'sh7fff_ffff;
                    2: r.value = 32'sh0000_0000;
                    3: r.value = 32'shffff_ffff;
                    default: r.value = $urandom;
                endcase
                if (sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 99) < idle_pct)
                begin
                    idle_for($urandom_range(1, 17));
                end
                send_request(r);
                sent++;
            end
            phase++;
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);

        $display("Checked %0d transactions over %0d traffic phases on %0d queues.",
                 checked, phase, NUM_QUEUES);
        $display("Refused on a full pool: %0d, answered empty: %0d, mismatches: %0d.",
                 full_hits, empty_hits, fail_count);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
